>>> rtl/pcs_pkg.sv
// Package for the periodic command scheduler table.
// Holds table sizes, operation and result codes, and the cell data types.
// No dependencies.
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RK_FIRED    = 3'd0,
    RK_NONE     = 3'd1,
    RK_ADDED    = 3'd2,
    RK_FULL     = 3'd3,
    RK_DELETED  = 3'd4,
    RK_NO_DEL   = 3'd5,
    RK_READ     = 3'd6,
    RK_NO_ENTRY = 3'd7
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] cd;
    logic [31:0] iv;
    logic [15:0] rep;
    logic [15:0] lim;
    logic [15:0] tag;
  } ent_t;

  typedef struct packed {
    logic fired;
    logic removed;
  } flg_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic shift;
    logic clr_fired;
  } cell_ctl_t;

endpackage

>>> rtl/pcs_if.sv
// Request and result channel interfaces for the scheduler table.
// Depends on nothing but the port widths of the block.
`timescale 1ns / 1ps
interface pcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  slot;
  logic [31:0] interval;
  logic [15:0] repeat_count;
  logic [15:0] command_tag;

  modport source (output valid, operation, slot, interval, repeat_count, command_tag,
                  input ready);
  modport sink (input valid, operation, slot, interval, repeat_count, command_tag,
                output ready);
endinterface

interface pcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  entry_slot;
  logic [15:0] fired_tag;
  logic [31:0] countdown_now;
  logic [31:0] interval_now;
  logic [15:0] repeats_now;
  logic [4:0]  occupancy;
  logic        final_result;

  modport source (output valid, result_kind, entry_slot, fired_tag, countdown_now,
                  interval_now, repeats_now, occupancy, final_result, input ready);
  modport sink (input valid, result_kind, entry_slot, fired_tag, countdown_now,
                interval_now, repeats_now, occupancy, final_result, output ready);
endinterface

>>> rtl/pcs_cell.sv
// One table entry of the scheduler: countdown, period, repeat limit and tag.
// Depends on pcs_pkg; takes its upper neighbor's contents on a shift.
`timescale 1ns / 1ps
module pcs_cell (
  input  logic              clk,
  input  logic              rst,
  input  pcs_pkg::cell_ctl_t ctl,
  input  pcs_pkg::ent_t     nb_ent,
  input  pcs_pkg::flg_t     nb_flg,
  input  pcs_pkg::ent_t     add_ent,
  output pcs_pkg::ent_t     ent,
  output pcs_pkg::flg_t     flg
);

  logic [31:0] cd_dec;
  logic        fire;

  assign cd_dec = ent.cd - 32'd1;
  assign fire   = (cd_dec == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      flg <= '0;
    end else if (ctl.shift) begin
      flg <= nb_flg;
    end else if (ctl.load) begin
      flg <= '0;
    end else if (ctl.tick) begin
      flg.fired   <= fire;
      flg.removed <= fire && (ent.rep == 16'd1);
    end else if (ctl.clr_fired) begin
      flg.fired <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent <= nb_ent;
    end else if (ctl.load) begin
      ent <= add_ent;
    end else if (ctl.tick) begin
      ent.cd <= fire ? ent.iv : cd_dec;
      if (fire) begin
        ent.lim <= ent.rep;
        if (ent.rep > 16'd1) begin
          ent.rep <= ent.rep - 16'd1;
        end
      end
    end
  end

endmodule

>>> rtl/periodic_command_scheduler_table.sv
// Top level of the scheduler table, a row of entry cells (pcs_pkg, pcs_if, pcs_cell).
// Add, delete and read: result registered, valid in the cycle after the request; one request
// per cycle while no tick is reporting and no result stalls. Tick: every occupied cell
// updates at the request edge; the fired flags are registered, then the results follow, one
// per cycle per fired entry in table order while not stalled (one "none fired" result if none).
// Synchronous reset empties the table and drops the result valid.
`timescale 1ns / 1ps
module periodic_command_scheduler_table (
  input logic clk,
  input logic rst,
  pcs_in_if.sink   cmd,
  pcs_out_if.source rsp
);

  localparam int D = pcs_pkg::TABLE_DEPTH;

  pcs_pkg::state_t state, state_next;
  logic [pcs_pkg::CNT_W-1:0] total;

  pcs_pkg::ent_t     ents [D];
  pcs_pkg::flg_t     flgs [D];
  pcs_pkg::cell_ctl_t ctls [D];
  pcs_pkg::ent_t     add_ent;

  logic                      load_ok, accept, emit_go, emit_rm, last_fire, load_rsp;
  logic [D-1:0]              pending, removed;
  logic [pcs_pkg::IDX_W-1:0] p;
  logic [pcs_pkg::CNT_W-1:0] rem_cnt;
  logic                      slot_ok, full;
  pcs_pkg::op_t              op;
  pcs_pkg::ent_t             rd_ent, em_ent;

  pcs_pkg::kind_t            kind_next;
  logic [3:0]                slot_next;
  logic [15:0]               tag_next, rep_next;
  logic [31:0]               cd_next, iv_next;
  logic [pcs_pkg::CNT_W-1:0] occ_next;
  logic                      fin_next;

  assign op      = pcs_pkg::op_t'(cmd.operation);
  assign add_ent = '{cd: cmd.interval, iv: cmd.interval, rep: cmd.repeat_count,
                     lim: 16'd0, tag: cmd.command_tag};
  assign slot_ok = ({1'b0, cmd.slot} < total);
  assign full    = (total >= pcs_pkg::CNT_W'(D));
  assign rd_ent  = ents[cmd.slot[pcs_pkg::IDX_W-1:0]];
  assign em_ent  = ents[p];

  always_comb begin
    p       = '0;
    rem_cnt = '0;
    for (int k = D - 1; k >= 0; k--) begin
      pending[k] = flgs[k].fired;
      removed[k] = flgs[k].removed;
      if (flgs[k].fired) begin
        p = pcs_pkg::IDX_W'(k);
      end
    end
    for (int k = 0; k < D; k++) begin
      rem_cnt = rem_cnt + pcs_pkg::CNT_W'(removed[k]);
    end
  end

  assign last_fire = ((pending & ~(D'(1) << p)) == '0);

  // Control outputs of the sequencer.
  always_comb begin
    load_ok   = !rsp.valid || rsp.ready;
    cmd.ready = (state == pcs_pkg::ST_IDLE) && load_ok;
    accept    = cmd.valid && cmd.ready;
    emit_go   = (state == pcs_pkg::ST_EMIT) && load_ok;
    emit_rm   = emit_go && pending[p] && removed[p];
  end

  assign load_rsp = (accept && op != pcs_pkg::OP_TICK) || emit_go;

  always_comb begin
    state_next = state;
    case (state)
      pcs_pkg::ST_IDLE: begin
        if (accept && op == pcs_pkg::OP_TICK) state_next = pcs_pkg::ST_EMIT;
      end
      pcs_pkg::ST_EMIT: begin
        if (emit_go && (pending == '0 || last_fire)) state_next = pcs_pkg::ST_IDLE;
      end
      default: state_next = pcs_pkg::ST_IDLE;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      logic below;
      assign below = (pcs_pkg::CNT_W'(g) < total);
      always_comb begin
        ctls[g].tick  = accept && op == pcs_pkg::OP_TICK && below;
        ctls[g].load  = accept && op == pcs_pkg::OP_ADD && !full &&
                        (pcs_pkg::CNT_W'(g) == total);
        ctls[g].shift = (accept && op == pcs_pkg::OP_DELETE && slot_ok &&
                         pcs_pkg::CNT_W'(g) >= {1'b0, cmd.slot}) ||
                        (emit_rm && pcs_pkg::IDX_W'(g) >= p);
        ctls[g].clr_fired = emit_go && pcs_pkg::IDX_W'(g) == p;
      end
      if (g == D - 1) begin : g_top
        pcs_cell u_cell (.clk(clk), .rst(rst), .ctl(ctls[g]), .nb_ent(ents[g]),
                         .nb_flg('0), .add_ent(add_ent), .ent(ents[g]), .flg(flgs[g]));
      end else begin : g_mid
        pcs_cell u_cell (.clk(clk), .rst(rst), .ctl(ctls[g]), .nb_ent(ents[g+1]),
                         .nb_flg(flgs[g+1]), .add_ent(add_ent), .ent(ents[g]),
                         .flg(flgs[g]));
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcs_pkg::ST_IDLE;
      total     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (accept && op == pcs_pkg::OP_ADD && !full) begin
        total <= total + 1'b1;
      end else if ((accept && op == pcs_pkg::OP_DELETE && slot_ok) || emit_rm) begin
        total <= total - 1'b1;
      end
    end
  end

  // Next result; fields without meaning for a kind are zero.
  always_comb begin
    kind_next = pcs_pkg::RK_NONE;
    slot_next = '0;
    tag_next  = '0;
    cd_next   = '0;
    iv_next   = '0;
    rep_next  = '0;
    occ_next  = total;
    fin_next  = 1'b1;
    if (accept && op != pcs_pkg::OP_TICK) begin
      slot_next = cmd.slot;
      case (op)
        pcs_pkg::OP_ADD: begin
          if (full) begin
            kind_next = pcs_pkg::RK_FULL;
            slot_next = '0;
          end else begin
            kind_next = pcs_pkg::RK_ADDED;
            slot_next = total[3:0];
            tag_next  = cmd.command_tag;
            cd_next   = cmd.interval;
            iv_next   = cmd.interval;
            rep_next  = cmd.repeat_count;
            occ_next  = total + 1'b1;
          end
        end
        pcs_pkg::OP_DELETE: begin
          if (slot_ok) begin
            kind_next = pcs_pkg::RK_DELETED;
            occ_next  = total - 1'b1;
          end else begin
            kind_next = pcs_pkg::RK_NO_DEL;
          end
        end
        default: begin
          if (slot_ok) begin
            kind_next = pcs_pkg::RK_READ;
            tag_next  = rd_ent.tag;
            cd_next   = rd_ent.cd;
            iv_next   = rd_ent.iv;
            rep_next  = rd_ent.rep;
          end else begin
            kind_next = pcs_pkg::RK_NO_ENTRY;
          end
        end
      endcase
    end else begin
      occ_next = total - rem_cnt;
      if (pending != '0) begin
        // Earlier removals are already compacted, so the cell index is the slot.
        kind_next = pcs_pkg::RK_FIRED;
        slot_next = 4'(p);
        tag_next  = em_ent.tag;
        cd_next   = em_ent.cd;
        iv_next   = em_ent.iv;
        rep_next  = em_ent.lim;
        fin_next  = last_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.result_kind   <= kind_next;
      rsp.entry_slot    <= slot_next;
      rsp.fired_tag     <= tag_next;
      rsp.countdown_now <= cd_next;
      rsp.interval_now  <= iv_next;
      rsp.repeats_now   <= rep_next;
      rsp.occupancy     <= occ_next;
      rsp.final_result  <= fin_next;
    end
  end

endmodule

>>> rtl/pcs_checker.sv
// Port-level checks for the scheduler table, bound to the top level.
// Depends on pcs_pkg and the periodic_command_scheduler_table ports.
`timescale 1ns / 1ps
module pcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_kind,
  input logic [4:0] rsp_occupancy,
  input logic       rsp_final
);

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_occupancy <= 5'(pcs_pkg::TABLE_DEPTH))
    else $error("occupancy above table depth");

  a_single_final: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind != pcs_pkg::RK_FIRED |-> rsp_final)
    else $error("non-firing result not marked final");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> !(rsp_valid && !rsp_final))
    else $error("request taken while a tick is still reporting");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
    else $error("stalled result changed");

endmodule

bind periodic_command_scheduler_table pcs_checker u_pcs_checker (
  .clk(clk), .rst(rst), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.result_kind),
  .rsp_occupancy(rsp.occupancy), .rsp_final(rsp.final_result)
);

>>> verif/testbench.sv
// Self-checking testbench for the periodic command scheduler table.
// Depends on pcs_pkg, the pcs_in_if/pcs_out_if interfaces and the block itself.
// A table model in the bench predicts every result, and a checker process compares them.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    pcs_pkg::kind_t kind;
    logic [3:0]  slot;
    logic [15:0] tag;
    logic [31:0] cd;
    logic [31:0] iv;
    logic [15:0] rep;
    logic [4:0]  occ;
    logic        fin;
  } sched_result_t;

  logic clk;
  logic rst;
  pcs_in_if  cmd ();
  pcs_out_if rsp ();

  periodic_command_scheduler_table dut (.clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source));

  // Table model: the bench's own copy of the scheduler state.
  logic [31:0] mdl_cd [pcs_pkg::TABLE_DEPTH];
  logic [31:0] mdl_iv [pcs_pkg::TABLE_DEPTH];
  logic [15:0] mdl_rep [pcs_pkg::TABLE_DEPTH];
  logic [15:0] mdl_tag [pcs_pkg::TABLE_DEPTH];
  int unsigned mdl_total;

  sched_result_t pending_results[$];
  int errors;
  int results_seen;
  int fired_seen;
  int op_count[4];
  bit gaps_on;
  bit hold_req;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Timeout at %0t", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void push_result(ref sched_result_t q[$], input pcs_pkg::kind_t k,
                                      input logic [3:0] s, input logic [15:0] t,
                                      input logic [31:0] c, input logic [31:0] i,
                                      input logic [15:0] r);
    sched_result_t e;
    e.kind = k; e.slot = s; e.tag = t; e.cd = c; e.iv = i; e.rep = r;
    e.occ = '0; e.fin = 1'b0;
    q.push_back(e);
  endfunction

  function automatic void remove_entry(int unsigned idx);
    for (int unsigned k = idx + 1; k < mdl_total; k++) begin
      mdl_cd[k-1] = mdl_cd[k];
      mdl_iv[k-1] = mdl_iv[k];
      mdl_rep[k-1] = mdl_rep[k];
      mdl_tag[k-1] = mdl_tag[k];
    end
    mdl_total--;
  endfunction

  function automatic void predict_schedule(pcs_pkg::op_t op, logic [3:0] slot,
                                           logic [31:0] ival, logic [15:0] rep,
                                           logic [15:0] tag);
    sched_result_t batch[$];
    int unsigned j;
    logic [15:0] lim;
    j = 0;
    case (op)
      pcs_pkg::OP_TICK: begin
        while (j < mdl_total) begin
          mdl_cd[j] = mdl_cd[j] - 32'd1;
          if (mdl_cd[j] == 32'd0) begin
            lim = mdl_rep[j];
            mdl_cd[j] = mdl_iv[j];
            push_result(batch, pcs_pkg::RK_FIRED, j[3:0], mdl_tag[j], mdl_cd[j], mdl_iv[j],
                        lim);
            if (lim > 16'd1) begin
              mdl_rep[j] = lim - 16'd1;
            end else if (lim == 16'd1) begin
              // The entry that slides into this place is handled in the same tick.
              remove_entry(j);
              continue;
            end
          end
          j++;
        end
        if (batch.size() == 0) push_result(batch, pcs_pkg::RK_NONE, '0, '0, '0, '0, '0);
      end
      pcs_pkg::OP_ADD: begin
        if (mdl_total >= pcs_pkg::TABLE_DEPTH) begin
          push_result(batch, pcs_pkg::RK_FULL, '0, '0, '0, '0, '0);
        end else begin
          j = mdl_total;
          mdl_cd[j] = ival; mdl_iv[j] = ival; mdl_rep[j] = rep; mdl_tag[j] = tag;
          mdl_total++;
          push_result(batch, pcs_pkg::RK_ADDED, j[3:0], tag, ival, ival, rep);
        end
      end
      pcs_pkg::OP_DELETE: begin
        if (slot < mdl_total) begin
          remove_entry(slot);
          push_result(batch, pcs_pkg::RK_DELETED, slot, '0, '0, '0, '0);
        end else begin
          push_result(batch, pcs_pkg::RK_NO_DEL, slot, '0, '0, '0, '0);
        end
      end
      default: begin
        if (slot < mdl_total) begin
          push_result(batch, pcs_pkg::RK_READ, slot, mdl_tag[slot], mdl_cd[slot],
                      mdl_iv[slot], mdl_rep[slot]);
        end else begin
          push_result(batch, pcs_pkg::RK_NO_ENTRY, slot, '0, '0, '0, '0);
        end
      end
    endcase
    foreach (batch[k]) begin
      batch[k].occ = mdl_total[4:0];
      batch[k].fin = (k == batch.size() - 1);
      pending_results.push_back(batch[k]);
    end
  endfunction

  // Result checker and receiver-side stalls.
  int stall_left;
  int long_hold;
  always @(posedge clk) begin
    sched_result_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
      long_hold = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d", $time, rsp.result_kind);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (e.kind == pcs_pkg::RK_FIRED) fired_seen++;
          if (rsp.result_kind !== e.kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, e.kind,
                     rsp.result_kind);
            errors++;
          end
          if (rsp.entry_slot !== e.slot) begin
            $display("%0t: entry_slot expected %0d actual %0d", $time, e.slot,
                     rsp.entry_slot);
            errors++;
          end
          if (rsp.fired_tag !== e.tag) begin
            $display("%0t: fired_tag expected %h actual %h", $time, e.tag, rsp.fired_tag);
            errors++;
          end
          if (rsp.countdown_now !== e.cd) begin
            $display("%0t: countdown_now expected %h actual %h", $time, e.cd,
                     rsp.countdown_now);
            errors++;
          end
          if (rsp.interval_now !== e.iv) begin
            $display("%0t: interval_now expected %h actual %h", $time, e.iv,
                     rsp.interval_now);
            errors++;
          end
          if (rsp.repeats_now !== e.rep) begin
            $display("%0t: repeats_now expected %h actual %h", $time, e.rep,
                     rsp.repeats_now);
            errors++;
          end
          if (rsp.occupancy !== e.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, rsp.occupancy);
            errors++;
          end
          if (rsp.final_result !== e.fin) begin
            $display("%0t: final_result expected %b actual %b", $time, e.fin,
                     rsp.final_result);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        long_hold = 80;
      end
      if (long_hold > 0) begin
        long_hold--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Sends one request; valid stays high between back-to-back requests unless gaps are enabled.
  task automatic send_request(pcs_pkg::op_t op, logic [3:0] slot, logic [31:0] ival,
                              logic [15:0] rep, logic [15:0] tag);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.operation <= op;
    cmd.slot <= slot;
    cmd.interval <= ival;
    cmd.repeat_count <= rep;
    cmd.command_tag <= tag;
    do @(posedge clk); while (!cmd.ready);
    op_count[op]++;
    predict_schedule(op, slot, ival, rep, tag);
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(pcs_pkg::OP_TICK, 4'd0, 32'd1, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_READ, 4'd0, 32'd1, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_DELETE, 4'd15, 32'd1, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_ADD, 4'd0, 32'd1, 16'd1, 16'hFFFF);
    send_request(pcs_pkg::OP_TICK, 4'd0, 32'd1, 16'd0, 16'd0);
    // Zero interval: countdown wraps on the next tick.
    send_request(pcs_pkg::OP_ADD, 4'd0, 32'd0, 16'd2, 16'h1234);
    send_request(pcs_pkg::OP_TICK, 4'd0, 32'd0, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_READ, 4'd0, 32'd0, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_ADD, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
    // Fill the table with entries that fire on every tick, then overflow it.
    for (int i = 2; i < pcs_pkg::TABLE_DEPTH; i++)
      send_request(pcs_pkg::OP_ADD, 4'd0, 32'd1, (i % 3 == 0) ? 16'd1 : 16'd0, 16'(i));
    send_request(pcs_pkg::OP_ADD, 4'd0, 32'd5, 16'd0, 16'hAAAA);
    send_request(pcs_pkg::OP_READ, 4'd15, 32'd0, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_TICK, 4'd0, 32'd0, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_DELETE, 4'(mdl_total - 1), 32'd0, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_DELETE, 4'd0, 32'd0, 16'd0, 16'd0);
    send_request(pcs_pkg::OP_READ, 4'd15, 32'd0, 16'd0, 16'd0);
    drain_results();
  endtask

  task automatic send_random_request();
    int unsigned pick;
    pcs_pkg::op_t op;
    logic [3:0] slot;
    logic [31:0] ival;
    logic [15:0] rep;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = pcs_pkg::OP_TICK;
    else if (pick < 70) op = pcs_pkg::OP_ADD;
    else if (pick < 85) op = pcs_pkg::OP_DELETE;
    else op = pcs_pkg::OP_READ;
    if (mdl_total > 0 && $urandom_range(0, 4) != 0) slot = 4'($urandom_range(0, mdl_total - 1));
    else slot = 4'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7) ival = $urandom_range(1, 4);
    else if (pick < 9) ival = $urandom_range(5, 40);
    else ival = $urandom;
    rep = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    send_request(op, slot, ival, rep, 16'($urandom));
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 15; i++)
      send_request((i % 2) ? pcs_pkg::OP_TICK : pcs_pkg::OP_ADD, 4'd0, 32'd1, 16'd0,
                   16'($urandom));
    drain_results();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_random_request();
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    errors = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    cmd.valid = 1'b0;
    cmd.operation = pcs_pkg::OP_TICK;
    cmd.slot = '0;
    cmd.interval = '0;
    cmd.repeat_count = '0;
    cmd.command_tag = '0;
    mdl_total = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(255);
    gaps_on = 1'b0;
    test_random(50);
    $display("Ran %0d ticks, %0d adds, %0d deletes, %0d reads.", op_count[pcs_pkg::OP_TICK],
             op_count[pcs_pkg::OP_ADD], op_count[pcs_pkg::OP_DELETE],
             op_count[pcs_pkg::OP_READ]);
    $display("Checked %0d results, %0d of them firings.", results_seen, fired_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
